FILE: design/ple_pkg.sv
`timescale 1ns / 1ps

package ple_pkg;

    localparam int CAPACITY_DEF = 32;

    localparam int POS_W    = 6;
    localparam int OP_W     = 2;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic                     ins;
        logic                     rem;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
    } cell_ctl_t;

endpackage

FILE: design/ple_if.sv
`timescale 1ns / 1ps

interface ple_req_if;
    logic                               valid;
    logic                               ready;
    logic [ple_pkg::OP_W-1:0]           op;
    logic [ple_pkg::POS_W-1:0]          pos;
    logic signed [ple_pkg::DATA_W-1:0]  value;

    modport source (output valid, output op, output pos, output value, input ready);
    modport sink   (input valid, input op, input pos, input value, output ready);
endinterface

interface ple_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [ple_pkg::STATUS_W-1:0]       status;
    logic signed [ple_pkg::DATA_W-1:0]  read_value;
    logic [ple_pkg::COUNT_W-1:0]        count;

    modport source (output valid, output status, output read_value, output count, input ready);
    modport sink   (input valid, input status, input read_value, input count, output ready);
endinterface

FILE: design/ple_cell.sv
`timescale 1ns / 1ps

// One list slot. Shifts up from the left neighbor on insert, down from the
// right neighbor on remove, depending on where it sits relative to pos.
module ple_cell #(
    parameter int INDEX = 0,
    parameter int IDX_W = 6
) (
    input  logic                              clk,
    input  ple_pkg::cell_ctl_t                ctl,
    input  logic signed [ple_pkg::DATA_W-1:0] left_value,
    input  logic signed [ple_pkg::DATA_W-1:0] right_value,
    output logic signed [ple_pkg::DATA_W-1:0] value,
    output logic signed [ple_pkg::DATA_W-1:0] read_data
);

    localparam logic [IDX_W-1:0] IDX = IDX_W'(INDEX);

    logic signed [ple_pkg::DATA_W-1:0] value_reg;
    logic [IDX_W-1:0]                  pos_ext;
    logic                              at_pos;
    logic                              above_pos;

    assign pos_ext   = IDX_W'(ctl.pos);
    assign at_pos    = (IDX == pos_ext);
    assign above_pos = (IDX > pos_ext);

    always_ff @(posedge clk)
    begin
        priority if (ctl.ins && at_pos)
        begin
            value_reg <= ctl.value;
        end
        else if (ctl.ins && above_pos)
        begin
            value_reg <= left_value;
        end
        else if (ctl.rem && (at_pos || above_pos))
        begin
            value_reg <= right_value;
        end
        else
        begin
            value_reg <= value_reg;
        end
    end

    assign value     = value_reg;
    assign read_data = at_pos ? value_reg : '0;

endmodule

FILE: design/positional_list_engine_unit.sv
`timescale 1ns / 1ps

// A result is registered and presented on rsp in the cycle after its request transfer.
// Throughput: one operation per cycle; a new request transfers whenever the
//   result register is empty or its result transfers in the same cycle.
// Insert and remove take effect on the accepting clock edge because every cell shifts at once.
// Reset clears the entry count and the result valid; cell contents are
//   left as they are and are only read below the count.
module positional_list_engine_unit #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    ple_req_if.sink       req,
    ple_rsp_if.source     rsp
);

    // count holds 0..CAPACITY; compares run at the wider of count and pos
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > ple_pkg::POS_W) ? CNT_W : ple_pkg::POS_W;

    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   count_next;
    logic                               out_valid_reg;
    logic [ple_pkg::STATUS_W-1:0]       status_reg;
    logic [ple_pkg::STATUS_W-1:0]       status_next;
    logic signed [ple_pkg::DATA_W-1:0]  read_value_reg;
    logic signed [ple_pkg::DATA_W-1:0]  read_value_next;
    logic [ple_pkg::COUNT_W-1:0]        count_out_reg;
    logic [CMP_W-1:0]                   count_wide_next;

    logic                               accept;
    logic [CMP_W-1:0]                   pos_ext;
    logic [CMP_W-1:0]                   count_ext;
    logic                               is_full;
    logic                               ins_ok;
    logic                               rem_ok;
    logic                               rd_ok;
    logic signed [ple_pkg::DATA_W-1:0]  rd_sel;

    ple_pkg::cell_ctl_t                 ctl;
    logic signed [ple_pkg::DATA_W-1:0]  cell_value [CAPACITY];
    logic signed [ple_pkg::DATA_W-1:0]  cell_read  [CAPACITY];

    // Handshake: the result register frees up in the cycle it transfers.
    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign pos_ext   = CMP_W'(req.pos);
    assign count_ext = CMP_W'(count_reg);
    assign is_full   = (count_reg == CNT_W'(CAPACITY));

    // Decode: the range check wins over the full check on insert; the
    // unused opcode reports out of range and changes nothing.
    always_comb
    begin
        status_next = ple_pkg::ST_OK;
        ins_ok      = 1'b0;
        rem_ok      = 1'b0;
        rd_ok       = 1'b0;
        priority if (req.op == ple_pkg::OP_INSERT)
        begin
            if (pos_ext > count_ext)
                status_next = ple_pkg::ST_RANGE;
            else if (is_full)
                status_next = ple_pkg::ST_FULL;
            else
                ins_ok = 1'b1;
        end
        else if (req.op == ple_pkg::OP_REMOVE)
        begin
            if (pos_ext >= count_ext)
                status_next = ple_pkg::ST_RANGE;
            else
                rem_ok = 1'b1;
        end
        else if (req.op == ple_pkg::OP_READ)
        begin
            if (pos_ext >= count_ext)
                status_next = ple_pkg::ST_RANGE;
            else
                rd_ok = 1'b1;
        end
        else
        begin
            status_next = ple_pkg::ST_RANGE;
        end
    end

    always_comb
    begin
        priority if (ins_ok)
            count_next = count_reg + CNT_W'(1);
        else if (rem_ok)
            count_next = count_reg - CNT_W'(1);
        else
            count_next = count_reg;
    end

    assign count_wide_next = CMP_W'(count_next);

    // Command broadcast; shifts only happen on an accepted, legal operation.
    assign ctl.ins   = accept && ins_ok;
    assign ctl.rem   = accept && rem_ok;
    assign ctl.pos   = req.pos;
    assign ctl.value = req.value;

    // Chain of cells: each takes from its left neighbor on insert and from
    // its right neighbor on remove. The ends see don't-care neighbors.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [ple_pkg::DATA_W-1:0] left_in;
        logic signed [ple_pkg::DATA_W-1:0] right_in;

        if (i == 0)
        begin : g_first
            assign left_in = req.value;
        end
        else
        begin : g_mid_l
            assign left_in = cell_value[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_in = cell_value[i];
        end
        else
        begin : g_mid_r
            assign right_in = cell_value[i+1];
        end

        ple_cell #(
            .INDEX (i),
            .IDX_W (CMP_W)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .left_value  (left_in),
            .right_value (right_in),
            .value       (cell_value[i]),
            .read_data   (cell_read[i])
        );
    end

    // Only the cell at pos drives nonzero read data, so an OR merges them.
    always_comb
    begin
        rd_sel = '0;
        for (int k = 0; k < CAPACITY; k++)
            rd_sel = rd_sel | cell_read[k];
    end

    assign read_value_next = rd_ok ? rd_sel : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, loaded on every request transfer.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg     <= status_next;
            read_value_reg <= read_value_next;
            count_out_reg  <= count_wide_next[ple_pkg::COUNT_W-1:0];
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.read_value = read_value_reg;
    assign rsp.count      = count_out_reg;

    // The list never grows past its capacity.
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // A legal insert grows the list by exactly one.
    a_ins_grows : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ins_ok) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the list by one");

    // A legal remove shrinks the list by exactly one.
    a_rem_shrinks : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && rem_ok) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("remove did not shrink the list by one");

    // Only a good status can carry read data.
    a_rd_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != ple_pkg::ST_OK)) |-> (read_value_reg == '0))
        else $error("nonzero read data on a failed operation");

    // The pending result's count tracks the live count.
    a_count_match : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (count_out_reg == count_ext[ple_pkg::COUNT_W-1:0]))
        else $error("reported count differs from list count");

endmodule
